// File: design/ufd_pkg.sv
// Shared types and constants for the form-encoded string decoder.
`timescale 1ns / 1ps

package ufd_pkg;

  // Most results one input item can produce.
  localparam int unsigned MAX_RES = 3;
  localparam int unsigned RES_IDX_W = $clog2(MAX_RES);
  localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);

  // Depth of the queue between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Characters with a special role.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UC_D  = 8'h44;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Results of one input item, in output order.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] res_byte;
    logic [MAX_RES-1:0]      res_has;
    logic [RES_CNT_W-1:0]    cnt;       // 1..MAX_RES
    logic                    eos;       // last result closes the string
  } bundle_t;

endpackage

// File: design/ufd_front.sv
// Front end: escape state machine, turns one character into a bundle of results.
`timescale 1ns / 1ps

module ufd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  output logic            bundle_push,
  output ufd_pkg::bundle_t bundle
);
  import ufd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PCT     = 3'd1,
    PH_FIRST   = 3'd2,
    PH_HOLD_D  = 3'd3,
    PH_HOLD_D0 = 3'd4
  } phase_t;

  localparam int unsigned SLOTS = MAX_RES + 2;

  phase_t     phase_r, phase_nxt;
  logic [3:0] nib_r, nib_nxt;
  logic       hex_r, hex_nxt;
  logic       zero_r, zero_nxt;

  logic [7:0] slot [SLOTS];
  logic [2:0] cnt;
  logic       do_idle;
  logic       hv_ok;
  logic [3:0] hv;

  // hex digit value, bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, c[3:0]};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, c[3:0] + 4'd9};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

  function automatic logic passes(input logic [7:0] c);
    logic p;
    p = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
        (c >= 8'h30 && c <= 8'h39);
    case (c)
      8'h24, 8'h2D, 8'h2E, 8'h5F, 8'h21, 8'h2A, 8'h28, 8'h29, 8'h2C: p = 1'b1;
      default: ;
    endcase
    return p;
  endfunction

  always_comb begin
    phase_nxt = phase_r;
    nib_nxt   = nib_r;
    hex_nxt   = hex_r;
    zero_nxt  = zero_r;
    cnt       = '0;
    do_idle   = 1'b0;
    for (int i = 0; i < SLOTS; i++) slot[i] = '0;
    {hv_ok, hv} = hex_val(in_byte);

    unique case (phase_r)
      PH_PCT: begin
        hex_nxt   = hv_ok;
        nib_nxt   = hv_ok ? hv : 4'd0;
        zero_nxt  = (in_byte == CH_ZERO);
        phase_nxt = PH_FIRST;
      end
      PH_FIRST: begin
        phase_nxt = PH_IDLE;
        if (zero_r && in_byte == CH_UC_D) begin
          phase_nxt = PH_HOLD_D;
        end else if (hex_r) begin
          slot[cnt] = hv_ok ? {nib_r, hv} : {4'd0, nib_r};
          cnt = cnt + 3'd1;
        end else begin
          slot[cnt] = CH_SPACE;
          cnt = cnt + 3'd1;
        end
      end
      PH_HOLD_D: begin
        if (in_byte == CH_ZERO) begin
          phase_nxt = PH_HOLD_D0;
        end else begin
          slot[cnt] = CH_CR;
          cnt = cnt + 3'd1;
          phase_nxt = PH_IDLE;
          do_idle = 1'b1;
        end
      end
      PH_HOLD_D0: begin
        phase_nxt = PH_IDLE;
        if (in_byte == CH_UC_A) begin
          slot[cnt] = CH_LF;
          cnt = cnt + 3'd1;
        end else begin
          slot[cnt] = CH_CR;
          cnt = cnt + 3'd1;
          slot[cnt] = CH_ZERO;
          cnt = cnt + 3'd1;
          do_idle = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        do_idle = 1'b1;
      end
    endcase

    if (do_idle) begin
      if (passes(in_byte)) begin
        slot[cnt] = in_byte;
        cnt = cnt + 3'd1;
      end else if (in_byte == CH_PLUS) begin
        slot[cnt] = CH_SPACE;
        cnt = cnt + 3'd1;
      end else if (in_byte == CH_PCT) begin
        phase_nxt = PH_PCT;
      end
    end

    // end of string: flush whatever escape is still open
    if (in_last) begin
      case (phase_nxt)
        PH_PCT: begin
          slot[cnt] = CH_SPACE;
          cnt = cnt + 3'd1;
        end
        PH_FIRST: begin
          slot[cnt] = hex_nxt ? {4'd0, nib_nxt} : CH_SPACE;
          cnt = cnt + 3'd1;
        end
        PH_HOLD_D: begin
          slot[cnt] = CH_CR;
          cnt = cnt + 3'd1;
        end
        PH_HOLD_D0: begin
          slot[cnt] = CH_CR;
          cnt = cnt + 3'd1;
          slot[cnt] = CH_ZERO;
          cnt = cnt + 3'd1;
        end
        default: ;
      endcase
      phase_nxt = PH_IDLE;
      nib_nxt   = '0;
      hex_nxt   = 1'b0;
      zero_nxt  = 1'b0;
    end

    // results past the third are dropped
    for (int i = 0; i < MAX_RES; i++) begin
      bundle.res_byte[i] = slot[i];
      bundle.res_has[i]  = (3'(i) < cnt);
    end
    if (cnt > 3'(MAX_RES))   bundle.cnt = RES_CNT_W'(MAX_RES);
    else if (cnt == 3'd0)    bundle.cnt = RES_CNT_W'(1);  // empty end marker
    else                     bundle.cnt = cnt[RES_CNT_W-1:0];
    bundle.eos  = in_last;
    bundle_push = accept && (cnt != 3'd0 || in_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      nib_r   <= '0;
      hex_r   <= 1'b0;
      zero_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      nib_r   <= nib_nxt;
      hex_r   <= hex_nxt;
      zero_r  <= zero_nxt;
    end
  end

endmodule

// File: design/ufd_fifo.sv
// Short bundle queue between front and back.
`timescale 1ns / 1ps

module ufd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  ufd_pkg::bundle_t wr_data,
  input  logic             rd_en,
  output ufd_pkg::bundle_t rd_data,
  output logic             q_full,
  output logic             q_empty
);
  import ufd_pkg::*;

  bundle_t             mem [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, rp_r;
  logic [QCNT_W-1:0]   cnt_r;

  assign q_full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + QPTR_W'(1);
      if (rd_en) rp_r <= rp_r + QPTR_W'(1);
      if (wr_en && !rd_en)      cnt_r <= cnt_r + QCNT_W'(1);
      else if (rd_en && !wr_en) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

endmodule

// File: design/ufd_back.sv
// Back end: unpacks bundles into single result items behind an output register.
`timescale 1ns / 1ps

module ufd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ufd_pkg::bundle_t head,
  input  logic             head_valid,
  output logic             head_pop,
  input  logic             out_pop,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             out_has_byte,
  output logic             out_end_of_string
);
  import ufd_pkg::*;

  logic                 valid_r;
  logic [7:0]           byte_r;
  logic                 has_r;
  logic                 eos_r;
  logic [RES_IDX_W-1:0] idx_r;
  logic                 load;
  logic                 at_end;

  assign load      = head_valid && (!valid_r || out_pop);
  assign at_end    = (RES_CNT_W'(idx_r) + RES_CNT_W'(1) == head.cnt);
  assign head_pop  = load && at_end;

  assign out_valid         = valid_r;
  assign out_byte          = byte_r;
  assign out_has_byte      = has_r;
  assign out_end_of_string = eos_r;

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.res_byte[idx_r];
      has_r  <= head.res_has[idx_r];
      eos_r  <= at_end && head.eos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load)         valid_r <= 1'b1;
      else if (out_pop) valid_r <= 1'b0;
      if (load) idx_r <= at_end ? '0 : idx_r + RES_IDX_W'(1);
    end
  end

endmodule

// File: design/url_form_decoder.sv
// Top level of the form-encoded (percent escape) string decoder.
`timescale 1ns / 1ps

// Channel   Handshake     Payload
// input     push / full   in_byte[7:0], in_last
// result    pop / empty   out_byte[7:0], out_has_byte, out_end_of_string
//
// One character is taken per cycle while the bundle queue (4 deep) has room.
// The front end decodes a character in the cycle it is taken and queues its
// results (up to three, or an empty end marker) as a bundle; the back end
// hands out one result item per cycle unless a stalled output holds it.
// Results pass through the bundle queue and then the output register.
// Reset (rst_n low, synchronous) clears escape state, queue and output register.
// A stalled output only blocks input once the queue fills.

module url_form_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_end_of_string
);
  import ufd_pkg::*;

  logic    accept;
  logic    bundle_push;
  bundle_t bundle;
  bundle_t head;
  logic    q_full;
  logic    q_empty;
  logic    head_pop;
  logic    out_valid;

  // input side sees the queue as its backpressure
  assign full   = q_full;
  assign accept = push && !q_full;
  assign empty  = !out_valid;

  // escape state machine, one character per cycle while the queue has room
  ufd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .bundle_push (bundle_push),
    .bundle      (bundle)
  );

  // decouples decode from result delivery
  ufd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (bundle_push),
    .wr_data (bundle),
    .rd_en   (head_pop),
    .rd_data (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // serializes bundles into result items
  ufd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .head_valid        (!q_empty),
    .head_pop          (head_pop),
    .out_pop           (pop),
    .out_valid         (out_valid),
    .out_byte          (out_byte),
    .out_has_byte      (out_has_byte),
    .out_end_of_string (out_end_of_string)
  );

endmodule

// File: sim/tb.sv
// Testbench for the form-encoded string decoder: directed and random strings.
`timescale 1ns / 1ps

module tb;
  import ufd_pkg::*;

  // Global guard, set well above the slowest legal run (clock period 2 ns).
  localparam int TIMEOUT_NS = 400_000;
  localparam int RANDOM_CHARS = 300;
  localparam int HOLD_CYCLES = 40;

  // Escape tracking of the decoder, mirrored here.
  typedef enum logic [2:0] {
    ESC_NONE,   // plain characters
    ESC_PCT,    // '%' seen
    ESC_FIRST,  // '%' and first escape character seen
    ESC_CR,     // "%0D" held, may turn into a newline
    ESC_CR0     // "%0D0" held
  } esc_state_t;

  typedef struct {
    logic [7:0] data;
    logic       has;
    logic       eos;
  } result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic       out_end_of_string;

  // Predictor state.
  esc_state_t esc_state = ESC_NONE;
  logic [3:0] first_val = 4'h0;
  logic       first_hex = 1'b0;
  logic       first_zero = 1'b0;

  result_t    char_results[$];   // results of the character being decoded
  result_t    exp_decoded[$];    // decoded items still owed by the block
  logic [7:0] str_buf[$];        // encoded string about to be sent

  int errors = 0;
  int sent_chars = 0;
  bit no_idle = 1'b0;            // both sides run without gaps
  int hold_cycles = 0;           // one-shot long stall of the result side

  url_form_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_byte          (in_byte),
    .in_last          (in_last),
    .empty            (empty),
    .pop              (pop),
    .out_byte         (out_byte),
    .out_has_byte     (out_has_byte),
    .out_end_of_string(out_end_of_string)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------------
  function automatic bit is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  // Digit value; zero for anything that is not a hex digit.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    int v;
    v = 0;
    if (c >= "0" && c <= "9") v = c - "0";
    else if (c >= "A" && c <= "F") v = c - "A" + 10;
    else if (c >= "a" && c <= "f") v = c - "a" + 10;
    return v[3:0];
  endfunction

  // Unreserved characters copied straight through.
  function automatic bit passes(input logic [7:0] c);
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9"))
      return 1'b1;
    return c == "$" || c == "-" || c == "." || c == "_" || c == "!" ||
           c == "*" || c == "(" || c == ")" || c == ",";
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic result_t mk(input logic [7:0] d);
    result_t r;
    r.data = d;
    r.has = 1'b1;
    r.eos = 1'b0;
    return r;
  endfunction

  // A character seen with no escape open.
  function automatic void plain_char(input logic [7:0] c);
    if (passes(c)) char_results.push_back(mk(c));
    else if (c == CH_PLUS) char_results.push_back(mk(CH_SPACE));
    else if (c == CH_PCT) esc_state = ESC_PCT;
  endfunction

  // Works out what one accepted character produces and queues it.
  function automatic void decode_char(input logic [7:0] c, input logic last_c);
    result_t r;
    char_results.delete();
    case (esc_state)
      ESC_PCT: begin
        first_hex = is_hex(c);
        first_val = hex_val(c);
        first_zero = (c == CH_ZERO);
        esc_state = ESC_FIRST;
      end
      ESC_FIRST: begin
        // second escape character is always eaten, even a '%'
        esc_state = ESC_NONE;
        if (first_zero && c == CH_UC_D) esc_state = ESC_CR;
        else if (first_hex && is_hex(c)) char_results.push_back(mk({first_val, hex_val(c)}));
        else if (first_hex) char_results.push_back(mk({4'h0, first_val}));
        else char_results.push_back(mk(CH_SPACE));
      end
      ESC_CR: begin
        if (c == CH_ZERO) begin
          esc_state = ESC_CR0;
        end else begin
          // broken newline: release the CR, then decode c from scratch
          char_results.push_back(mk(CH_CR));
          esc_state = ESC_NONE;
          plain_char(c);
        end
      end
      ESC_CR0: begin
        esc_state = ESC_NONE;
        if (c == CH_UC_A) begin
          char_results.push_back(mk(CH_LF));
        end else begin
          char_results.push_back(mk(CH_CR));
          char_results.push_back(mk(CH_ZERO));
          plain_char(c);
        end
      end
      default: begin
        esc_state = ESC_NONE;
        plain_char(c);
      end
    endcase

    if (last_c) begin
      // end of string flushes whatever is still held
      case (esc_state)
        ESC_PCT:   char_results.push_back(mk(CH_SPACE));
        ESC_FIRST: char_results.push_back(mk(first_hex ? {4'h0, first_val} : CH_SPACE));
        ESC_CR:    char_results.push_back(mk(CH_CR));
        ESC_CR0: begin
          char_results.push_back(mk(CH_CR));
          char_results.push_back(mk(CH_ZERO));
        end
        default: ;
      endcase
      esc_state = ESC_NONE;
      first_val = 4'h0;
      first_hex = 1'b0;
      first_zero = 1'b0;
      if (char_results.size() == 0) begin
        r.data = 8'h00;
        r.has = 1'b0;
        r.eos = 1'b0;
        char_results.push_back(r);
      end
      char_results[char_results.size() - 1].eos = 1'b1;
    end

    foreach (char_results[i]) exp_decoded.push_back(char_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // push stays high after acceptance so back-to-back items need no extra edge;
  // anything that lets time pass without sending must drop it first.
  task automatic send_item(input logic [7:0] c, input logic last_c, input int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= c;
    in_last <= last_c;
    @(posedge clk);
    while (full) @(posedge clk);
    decode_char(c, last_c);
    sent_chars++;
  endtask

  task automatic send_buf(input bit end_str);
    foreach (str_buf[i])
      send_item(str_buf[i], end_str && (i == str_buf.size() - 1), draw_gap());
  endtask

  function automatic void fill_text(input string s);
    for (int i = 0; i < s.len(); i++) str_buf.push_back(s[i]);
  endfunction

  // Stop offering items and wait until every decoded item has been taken.
  task automatic wait_drain();
    push <= 1'b0;
    while (exp_decoded.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random character pickers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_pass();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (!passes(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_hex();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'("0" + v);
    if (v < 16) return 8'("A" + v - 10);
    return 8'("a" + v - 16);
  endfunction

  function automatic logic [7:0] pick_nonhex();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) return CH_PCT;
    do c = 8'($urandom_range(0, 255)); while (is_hex(c));
    return c;
  endfunction

  // Mostly meaningful characters, some escapes, some raw noise.
  function automatic logic [7:0] pick_any();
    int v;
    v = $urandom_range(0, 9);
    if (v < 5) return pick_pass();
    if (v < 7) return CH_PCT;
    return 8'($urandom_range(0, 255));
  endfunction

  // Appends one encoded token to str_buf. Weighted toward well-formed escapes.
  task automatic add_token();
    int kind;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 28) begin
      str_buf.push_back(pick_pass());
    end else if (kind < 35) begin
      str_buf.push_back(CH_PLUS);
    end else if (kind < 55) begin
      str_buf.push_back(CH_PCT);
      str_buf.push_back(pick_hex());
      str_buf.push_back(pick_hex());
    end else if (kind < 61) begin
      // one hex digit only
      str_buf.push_back(CH_PCT);
      str_buf.push_back(pick_hex());
      str_buf.push_back(pick_nonhex());
    end else if (kind < 66) begin
      // first escape character not hex
      str_buf.push_back(CH_PCT);
      str_buf.push_back(pick_nonhex());
      str_buf.push_back(pick_any());
    end else if (kind < 74) begin
      fill_text("%0D0A");
    end else if (kind < 82) begin
      // newline sequence broken after "%0D" or after "%0D0"
      fill_text("%0D");
      if ($urandom_range(0, 1)) begin
        str_buf.push_back(CH_ZERO);
        do c = pick_any(); while (c == CH_UC_A);
      end else begin
        do c = pick_any(); while (c == CH_ZERO);
      end
      str_buf.push_back(c);
    end else if (kind < 92) begin
      str_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      // open escape; flushed if it ends the string
      case ($urandom_range(0, 3))
        0: fill_text("%");
        1: begin
          str_buf.push_back(CH_PCT);
          str_buf.push_back(pick_any());
        end
        2: fill_text("%0D");
        default: fill_text("%0D0");
      endcase
    end
  endtask

  task automatic send_random_string();
    str_buf.delete();
    repeat ($urandom_range(1, 5)) add_token();
    send_buf(1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Pass-through set, '+', and a string whose last char yields nothing.
  task automatic test_passthrough();
    str_buf.delete();
    fill_text("Az9$+");
    str_buf.push_back(8'h00);
    str_buf.push_back(8'hFF);
    send_buf(1'b1);
  endtask

  // Two-digit, one-digit and non-hex escapes; '%' as second char is eaten.
  task automatic test_escapes();
    str_buf.delete();
    fill_text("%aF%4g%%%");
    send_buf(1'b1);
  endtask

  // Full CRLF escape, then an unfinished one flushed at end of string.
  task automatic test_newline();
    str_buf.delete();
    fill_text("%0D0A%0D0");
    send_buf(1'b1);
  endtask

  // Output held off long enough for the bundle queue to fill and stall input.
  task automatic test_backpressure();
    wait_drain();
    hold_cycles = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) send_item(pick_pass(), i == 23, 0);
    wait_drain();
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (4) send_random_string();
    no_idle = 1'b0;
  endtask

  task automatic test_random();
    int stop_at;
    stop_at = sent_chars + RANDOM_CHARS;
    while (sent_chars < stop_at) send_random_string();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, one-shot long hold, compare against predictor
  // ---------------------------------------------------------------------------
  task automatic check_result(input logic [7:0] d, input logic h, input logic e);
    result_t want;
    if (exp_decoded.size() == 0) begin
      errors++;
      $display("%0t: unexpected item out_byte=%02h has_byte=%0b end_of_string=%0b",
               $time, d, h, e);
      return;
    end
    want = exp_decoded.pop_front();
    if (d !== want.data) begin
      errors++;
      $display("%0t: out_byte expected %02h actual %02h", $time, want.data, d);
    end
    if (h !== want.has) begin
      errors++;
      $display("%0t: out_has_byte expected %0b actual %0b", $time, want.has, h);
    end
    if (e !== want.eos) begin
      errors++;
      $display("%0t: out_end_of_string expected %0b actual %0b", $time, want.eos, e);
    end
  endtask

  initial begin : result_side
    int stall;
    wait (rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      check_result(out_byte, out_has_byte, out_end_of_string);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_passthrough();
    test_escapes();
    test_newline();
    test_backpressure();
    test_back_to_back();
    test_random();

    // let stragglers show up as unexpected items
    wait_drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
